>>> src/set_assoc_tag_store_lru_defines.svh
// Assertion macros shared by the tag store RTL.
`ifndef SET_ASSOC_TAG_STORE_LRU_DEFINES_SVH
`define SET_ASSOC_TAG_STORE_LRU_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SATAG_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SATAG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/satag_pkg.sv
// Package with the beat types and codes of the set-associative tag store.
`default_nettype none

package satag_pkg;

   localparam logic REQ_ACCESS     = 1'b0;
   localparam logic REQ_INVALIDATE = 1'b1;

   localparam logic [1:0] LINE_INVALID = 2'd0;

   localparam int SET_FIELD_CODES = 256;
   localparam int TAG_FIELD_BITS  = 12;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  set_index;
      logic [11:0] tag;
      logic [1:0]  fill_state;
   } req_beat_type;

   typedef struct packed {
      logic        hit;
      logic [1:0]  way;
      logic        evicted;
      logic [11:0] victim_tag;
      logic [1:0]  victim_state;
   } rsp_beat_type;

endpackage

`default_nettype wire

>>> src/set_assoc_tag_store_lru.sv
// Top level of the set-associative tag store with counter LRU replacement.
`default_nettype none

// An access beat is taken only while the block is idle. The set row is read from the memories
// at the accepting edge. The tags are compared and the way is chosen in the next cycle. The
// row is then written back with the new tag, state and ages as the result is loaded. A new
// access can be accepted also while the previous result still waits in the output register.
// The write-back waits for as long as that register stays full. An invalidate-all beat sweeps
// the state memory one set per cycle, then loads its result, and the input is held off until
// that result is loaded. After reset a clearing pass writes every set's states and ages; no
// beat is accepted during it. A set index of SETS or more wraps modulo SETS; a tag wider than
// TAG_BITS keeps its low bits.
module set_assoc_tag_store_lru
   import satag_pkg::*;
#(
   parameter int WAYS     = 4,
   parameter int SETS     = 256,
   parameter int TAG_BITS = 12
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_beat_type req_beat,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_beat_type      rsp_beat
);

`include "set_assoc_tag_store_lru_defines.svh"

   localparam int AGE_BITS = $clog2(WAYS);
   localparam int WAY_BITS = $clog2(WAYS);
   localparam int IDX_BITS = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int ROW_BITS = TAG_BITS + AGE_BITS;
   localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(SETS - 1);
   localparam logic [AGE_BITS-1:0] OLDEST_AGE = AGE_BITS'(WAYS - 1);

   localparam logic [2:0] ST_CLR     = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_LOOK    = 3'd2;
   localparam logic [2:0] ST_UPD     = 3'd3;
   localparam logic [2:0] ST_INV     = 3'd4;
   localparam logic [2:0] ST_INV_RSP = 3'd5;

   function automatic logic [WAYS-1:0] first_one(input logic [WAYS-1:0] v);
      logic [WAYS-1:0] res;
      res = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (v[i]) begin
            res    = '0;
            res[i] = 1'b1;
         end
      end
      return res;
   endfunction

   logic [WAYS-1:0][ROW_BITS-1:0] ta_mem [SETS];
   logic [WAYS-1:0][1:0]          st_mem [SETS];

   logic [IDX_BITS-1:0] set_map [SET_FIELD_CODES];

   logic [2:0]                    state_ff, state_in;
   logic [IDX_BITS-1:0]           idx_ff, idx_in;
   logic [IDX_BITS-1:0]           req_set_ff;
   logic [TAG_BITS-1:0]           req_tag_ff;
   logic [1:0]                    req_fill_ff;
   logic [WAYS-1:0][ROW_BITS-1:0] ta_rd_ff;
   logic [WAYS-1:0][1:0]          st_rd_ff;
   logic [WAYS-1:0]               way_oh_ff, way_oh_in;
   logic                          hit_ff, hit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_beat_type                  rsp_ff, rsp_in;

   logic accept, rd_en, out_free, upd_fire, rsp_load, sweep_last;
   logic ta_we, st_we;
   logic [IDX_BITS-1:0]           wr_addr, rd_addr;
   logic [WAYS-1:0][ROW_BITS-1:0] ta_wdata, clr_row, upd_row;
   logic [WAYS-1:0][1:0]          st_wdata, upd_st_row;

   logic [WAYS-1:0][TAG_BITS-1:0] rd_tag;
   logic [WAYS-1:0][AGE_BITS-1:0] rd_age, new_age;
   logic [WAYS-1:0]               hit_vec, inval_vec, oldest_vec;
   logic [AGE_BITS-1:0]           used_age;
   logic [WAY_BITS-1:0]           way_idx;
   logic [TAG_BITS-1:0]           vic_tag;
   logic [1:0]                    vic_state;
   logic                          evict;

   for (genvar g = 0; g < SET_FIELD_CODES; g++) begin : g_set_map
      assign set_map[g] = IDX_BITS'(g % SETS);
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign rd_en      = accept && (req_beat.req_type == REQ_ACCESS);
   assign rd_addr    = set_map[req_beat.set_index];
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign upd_fire   = (state_ff == ST_UPD) && out_free;
   assign rsp_load   = upd_fire || ((state_ff == ST_INV_RSP) && out_free);
   assign sweep_last = (idx_ff == LAST_IDX);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_beat   = rsp_ff;

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         rd_tag[i]     = ta_rd_ff[i][ROW_BITS-1:AGE_BITS];
         rd_age[i]     = ta_rd_ff[i][AGE_BITS-1:0];
         hit_vec[i]    = (st_rd_ff[i] != LINE_INVALID) && (rd_tag[i] == req_tag_ff);
         inval_vec[i]  = (st_rd_ff[i] == LINE_INVALID);
         oldest_vec[i] = (rd_age[i] == OLDEST_AGE);
         clr_row[i]    = {{TAG_BITS{1'b0}}, AGE_BITS'(i)};
      end
      hit_in = |hit_vec;
      if (|hit_vec) begin
         way_oh_in = first_one(hit_vec);
      end else if (|inval_vec) begin
         way_oh_in = first_one(inval_vec);
      end else begin
         way_oh_in = oldest_vec;
      end
   end

   always_comb begin
      used_age  = '0;
      way_idx   = '0;
      vic_tag   = '0;
      vic_state = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (way_oh_ff[i]) begin
            used_age  = used_age | rd_age[i];
            way_idx   = way_idx | WAY_BITS'(i);
            vic_tag   = vic_tag | rd_tag[i];
            vic_state = vic_state | st_rd_ff[i];
         end
      end
      for (int i = 0; i < WAYS; i++) begin
         if (way_oh_ff[i]) begin
            new_age[i] = '0;
         end else if (rd_age[i] < used_age) begin
            new_age[i] = rd_age[i] + AGE_BITS'(1);
         end else begin
            new_age[i] = rd_age[i];
         end
         if (way_oh_ff[i] && !hit_ff) begin
            upd_row[i]    = {req_tag_ff, new_age[i]};
            upd_st_row[i] = req_fill_ff;
         end else begin
            upd_row[i]    = {rd_tag[i], new_age[i]};
            upd_st_row[i] = st_rd_ff[i];
         end
      end
      evict = !hit_ff && (vic_state != LINE_INVALID);
   end

   always_comb begin
      ta_we    = (state_ff == ST_CLR) || upd_fire;
      st_we    = (state_ff == ST_CLR) || (state_ff == ST_INV) || upd_fire;
      wr_addr  = ((state_ff == ST_CLR) || (state_ff == ST_INV)) ? idx_ff : req_set_ff;
      ta_wdata = (state_ff == ST_CLR) ? clr_row : upd_row;
      st_wdata = ((state_ff == ST_CLR) || (state_ff == ST_INV)) ? '0 : upd_st_row;
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_CLR, ST_INV: begin
            idx_in = sweep_last ? '0 : idx_ff + IDX_BITS'(1);
            if (sweep_last) begin
               state_in = (state_ff == ST_CLR) ? ST_IDLE : ST_INV_RSP;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_beat.req_type == REQ_ACCESS) ? ST_LOOK : ST_INV;
            end
         end
         ST_LOOK: state_in = ST_UPD;
         ST_UPD, ST_INV_RSP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLR;
      endcase
   end

   always_comb begin
      rsp_in = '0;
      if (state_ff == ST_UPD) begin
         rsp_in.hit          = hit_ff;
         rsp_in.way          = 2'(way_idx);
         rsp_in.evicted      = evict;
         rsp_in.victim_tag   = evict ? TAG_FIELD_BITS'(vic_tag) : '0;
         rsp_in.victim_state = hit_ff ? LINE_INVALID : vic_state;
      end
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_set_ff  <= rd_addr;
         req_tag_ff  <= TAG_BITS'(req_beat.tag);
         req_fill_ff <= req_beat.fill_state;
      end
      if (state_ff == ST_LOOK) begin
         way_oh_ff <= way_oh_in;
         hit_ff    <= hit_in;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         ta_rd_ff <= ta_mem[rd_addr];
         st_rd_ff <= st_mem[rd_addr];
      end
      if (ta_we) begin
         ta_mem[wr_addr] <= ta_wdata;
      end
      if (st_we) begin
         st_mem[wr_addr] <= st_wdata;
      end
   end

   `SATAG_ASSERT_NOW(a_ages_permutation, state_ff == ST_LOOK, $onehot(oldest_vec), "no oldest way")
   `SATAG_ASSERT_NOW(a_way_onehot, state_ff == ST_UPD, $onehot(way_oh_ff), "way not one-hot")
   `SATAG_ASSERT_NEXT(a_rsp_after_upd, upd_fire, rsp_valid_ff, "update did not load a result")
   `SATAG_ASSERT_NOW(a_hit_no_evict, rsp_valid_ff, !rsp_ff.hit || !rsp_ff.evicted, "hit evicted")

endmodule

`default_nettype wire

>>> test/set_assoc_tag_store_lru_checker.sv
// Checker that predicts and compares every response beat of the tag store.
`timescale 1ns / 1ps

module set_assoc_tag_store_lru_checker
   import satag_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_ready,
   input  wire req_beat_type req_beat,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_ready,
   input  wire rsp_beat_type rsp_beat,
   output int                fail_count,
   output int                pending_results
);

   localparam int NUM_WAYS = 4;
   localparam int NUM_SETS = SET_FIELD_CODES;

   logic [TAG_FIELD_BITS-1:0] line_tag_q   [NUM_SETS][NUM_WAYS];
   logic [1:0]                line_state_q [NUM_SETS][NUM_WAYS];
   logic [1:0]                line_age_q   [NUM_SETS][NUM_WAYS];

   rsp_beat_type expected_rsp_q[$];
   int           errors = 0;

   function automatic void clear_lines();
      for (int s = 0; s < NUM_SETS; s++) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            line_tag_q[s][w]   = '0;
            line_state_q[s][w] = LINE_INVALID;
            line_age_q[s][w]   = 2'(w);
         end
      end
   endfunction

   function automatic void make_newest(int s, int w);
      logic [1:0] used_age;
      used_age = line_age_q[s][w];
      for (int i = 0; i < NUM_WAYS; i++) begin
         if (i != w && line_age_q[s][i] < used_age) begin
            line_age_q[s][i] = line_age_q[s][i] + 2'd1;
         end
      end
      line_age_q[s][w] = 2'd0;
   endfunction

   function automatic rsp_beat_type lookup_and_fill(req_beat_type req);
      rsp_beat_type res;
      int           s;
      int           victim;
      res = '0;
      if (req.req_type == REQ_INVALIDATE) begin
         for (int i = 0; i < NUM_SETS; i++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
               line_state_q[i][w] = LINE_INVALID;
            end
         end
         return res;
      end
      s = int'(req.set_index) % NUM_SETS;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (line_state_q[s][w] != LINE_INVALID && line_tag_q[s][w] == req.tag) begin
            make_newest(s, w);
            res.hit = 1'b1;
            res.way = 2'(w);
            return res;
         end
      end
      victim = -1;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (victim < 0 && line_state_q[s][w] == LINE_INVALID) begin
            victim = w;
         end
      end
      if (victim < 0) begin
         victim = 0;
         for (int w = 1; w < NUM_WAYS; w++) begin
            if (line_age_q[s][w] > line_age_q[s][victim]) begin
               victim = w;
            end
         end
      end
      res.way          = 2'(victim);
      res.victim_state = line_state_q[s][victim];
      if (line_state_q[s][victim] != LINE_INVALID) begin
         res.evicted    = 1'b1;
         res.victim_tag = line_tag_q[s][victim];
      end
      line_tag_q[s][victim]   = req.tag;
      line_state_q[s][victim] = req.fill_state;
      make_newest(s, victim);
      return res;
   endfunction

   function automatic void check_field(string name, logic [11:0] exp_val, logic [11:0] got_val);
      if (got_val !== exp_val) begin
         $error("%s: expected %0h, actual %0h", name, exp_val, got_val);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         clear_lines();
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("Response beat arrived with no request outstanding.");
               errors++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("hit", 12'(want.hit), 12'(rsp_beat.hit));
               check_field("way", 12'(want.way), 12'(rsp_beat.way));
               check_field("evicted", 12'(want.evicted), 12'(rsp_beat.evicted));
               check_field("victim_tag", want.victim_tag, rsp_beat.victim_tag);
               check_field("victim_state", 12'(want.victim_state),
                           12'(rsp_beat.victim_state));
            end
         end
         if (req_valid && req_ready) begin
            expected_rsp_q.push_back(lookup_and_fill(req_beat));
         end
      end
      fail_count      <= errors;
      pending_results <= expected_rsp_q.size();
   end

endmodule

>>> test/set_assoc_tag_store_lru_tb.sv
// Testbench top that drives the tag store and reports the verdict.
`timescale 1ns / 1ps

module set_assoc_tag_store_lru_tb
   import satag_pkg::*;
;

   localparam logic [1:0] FILL_SHARED    = 2'd1;
   localparam logic [1:0] FILL_EXCLUSIVE = 2'd2;
   localparam logic [1:0] FILL_MODIFIED  = 2'd3;

   localparam int RANDOM_BEATS   = 1600;
   localparam int QUIET_BEATS    = 200;
   localparam int HOLD_OFF_AT    = 500;
   localparam int DRAIN_AT       = 1000;
   localparam int LONG_HOLD_OFF  = 60;
   localparam int TAIL_CYCLES    = 12;
   localparam int WATCHDOG_LIMIT = 4000;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_beat_type req_beat  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_beat_type rsp_beat;

   int fail_count;
   int pending_results;
   int idle_cycles = 0;
   int rsp_stall_left = 0;
   int holdoffs_asked = 0;
   int holdoffs_served = 0;
   bit quiet_tail = 1'b0;

   logic [7:0]  hot_sets [4];
   logic [11:0] hot_tags [6];

   set_assoc_tag_store_lru u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

   set_assoc_tag_store_lru_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_beat        (req_beat),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_beat        (rsp_beat),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall_left = 0;
      end else begin
         if (rsp_stall_left == 0 && holdoffs_served != holdoffs_asked) begin
            holdoffs_served++;
            rsp_stall_left = LONG_HOLD_OFF;
         end else if (rsp_stall_left == 0 && !quiet_tail && $urandom_range(0, 6) == 0) begin
            rsp_stall_left = $urandom_range(1, 5);
         end
         if (rsp_stall_left > 0) begin
            rsp_ready <= 1'b0;
            rsp_stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_beat_type make_beat(logic kind, logic [7:0] set_idx,
                                              logic [11:0] tag_val, logic [1:0] fill);
      req_beat_type b;
      b.req_type   = kind;
      b.set_index  = set_idx;
      b.tag        = tag_val;
      b.fill_state = fill;
      return b;
   endfunction

   function automatic req_beat_type random_beat();
      int          pick;
      logic [1:0]  fill;
      pick = $urandom_range(0, 99);
      fill = ($urandom_range(0, 31) == 0) ? LINE_INVALID
                                          : 2'($urandom_range(FILL_SHARED, FILL_MODIFIED));
      if (pick < 2) begin
         return make_beat(REQ_INVALIDATE, 8'($urandom), 12'($urandom), 2'($urandom));
      end else if (pick < 80) begin
         return make_beat(REQ_ACCESS, hot_sets[$urandom_range(0, 3)],
                          hot_tags[$urandom_range(0, 5)], fill);
      end
      return make_beat(REQ_ACCESS, 8'($urandom), 12'($urandom), fill);
   endfunction

   task automatic send_beat(input req_beat_type b);
      req_valid <= 1'b1;
      req_beat  <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic idle_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   initial begin
      foreach (hot_sets[i]) hot_sets[i] = 8'($urandom);
      foreach (hot_tags[i]) hot_tags[i] = 12'($urandom);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_beat(make_beat(REQ_ACCESS, 8'h00, 12'h000, FILL_SHARED));
      send_beat(make_beat(REQ_ACCESS, 8'h00, 12'hFFF, FILL_MODIFIED));
      send_beat(make_beat(REQ_ACCESS, 8'h00, 12'h555, FILL_EXCLUSIVE));
      send_beat(make_beat(REQ_ACCESS, 8'h00, 12'hAAA, FILL_SHARED));
      send_beat(make_beat(REQ_ACCESS, 8'h00, 12'h000, FILL_EXCLUSIVE));
      send_beat(make_beat(REQ_ACCESS, 8'h00, 12'h123, FILL_MODIFIED));
      send_beat(make_beat(REQ_ACCESS, 8'h00, 12'hFFF, FILL_SHARED));
      send_beat(make_beat(REQ_ACCESS, 8'hFF, 12'hFFF, FILL_MODIFIED));
      send_beat(make_beat(REQ_ACCESS, 8'hFF, 12'hFFF, FILL_SHARED));
      send_beat(make_beat(REQ_ACCESS, 8'h80, 12'h7FF, LINE_INVALID));
      send_beat(make_beat(REQ_ACCESS, 8'h80, 12'h7FF, FILL_SHARED));
      send_beat(make_beat(REQ_ACCESS, 8'h80, 12'h7FF, FILL_EXCLUSIVE));
      send_beat(make_beat(REQ_INVALIDATE, 8'hFF, 12'hFFF, FILL_MODIFIED));
      send_beat(make_beat(REQ_ACCESS, 8'h00, 12'h000, FILL_SHARED));
      send_beat(make_beat(REQ_ACCESS, 8'hFF, 12'hFFF, FILL_EXCLUSIVE));
      send_beat(make_beat(REQ_ACCESS, 8'h80, 12'h7FF, FILL_MODIFIED));
      send_beat(make_beat(REQ_INVALIDATE, 8'h00, 12'h000, LINE_INVALID));
      send_beat(make_beat(REQ_ACCESS, 8'h80, 12'h7FF, FILL_SHARED));

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == HOLD_OFF_AT) holdoffs_asked++;
         if (n == DRAIN_AT) wait_drained();
         if (n >= RANDOM_BEATS - QUIET_BEATS) begin
            quiet_tail = 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            idle_gap($urandom_range(1, 5));
         end
         send_beat(random_beat());
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
